// ----- design/fts_pkg.sv -----
// Shared types and constants for the FIFO thread scheduler.
`default_nettype none

package fts_pkg;

  // Default number of thread slots
  localparam int unsigned SLOTS_DEF = 16;

  // Field widths
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FREED_W  = 5;

  // Saturation point of the reap count
  localparam int unsigned FREED_MAX = 31;

  // Slot number used by the idle thread after reset
  localparam logic [SLOT_W-1:0] IDLE_RST = 4'd1;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADMIT     = 3'd0,
    REQ_YIELD     = 3'd1,
    REQ_BLOCK     = 3'd2,
    REQ_UNBLOCK   = 3'd3,
    REQ_TERMINATE = 3'd4,
    REQ_REAP      = 3'd5
  } req_e;

  // Per-slot thread state
  typedef enum logic [2:0] {
    ST_FREE       = 3'd0,
    ST_READY      = 3'd1,
    ST_RUNNING    = 3'd2,
    ST_BLOCKED    = 3'd3,
    ST_TERMINATED = 3'd4
  } slot_st_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_DONE     = 2'd0,
    STS_IGNORED  = 2'd1,
    STS_REJECTED = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ----- design/fts_req_if.sv -----
// Request channel interface: valid/ready with the scheduling event payload.
`default_nettype none

interface fts_req_if;
  logic                        valid;
  logic                        ready;
  logic [fts_pkg::REQ_W-1:0]   req_type;
  logic [fts_pkg::SLOT_W-1:0]  thread_slot;

  modport source (output valid, output req_type, output thread_slot, input ready);
  modport sink   (input valid, input req_type, input thread_slot, output ready);
endinterface

`default_nettype wire

// ----- design/fts_res_if.sv -----
// Result channel interface: valid/ready with the scheduling result payload.
`default_nettype none

interface fts_res_if;
  logic                          valid;
  logic                          ready;
  logic [fts_pkg::SLOT_W-1:0]    running_slot;
  logic                          switched;
  logic [fts_pkg::SLOT_W-1:0]    previous_slot;
  logic [fts_pkg::STATUS_W-1:0]  status;
  logic [fts_pkg::FREED_W-1:0]   freed_count;

  modport source (output valid, output running_slot, output switched,
                  output previous_slot, output status, output freed_count,
                  input ready);
  modport sink   (input valid, input running_slot, input switched,
                  input previous_slot, input status, input freed_count,
                  output ready);
endinterface

`default_nettype wire

// ----- design/fifo_thread_scheduler_unit.sv -----
// Top level of the FIFO thread scheduler: slot states, ready queue, running slot.
//
//  channel   dir  handshake        payload
//  req_i     in   valid/ready      req_type[2:0], thread_slot[3:0]
//  res_o     out  valid/ready      running_slot, switched, previous_slot,
//                                  status[1:0], freed_count[4:0]
//  cfg       in   cfg_we_i         cfg_wdata_i[3:0] -> idle_slot
//
// One request per cycle sustained while results are taken; each result is
// registered after its request is taken into the input register. The whole
// event is evaluated in one pass between the input register and the result
// register; the ready queue head comes from a registered-read RAM
// addressed by the next head pointer, with a write-through bypass. Reset
// clears slot states (slot 0 running), queue pointers and the running slot
// at once; the queue RAM needs no clearing pass. A stalled result holds; the
// input register keeps taking requests as long as the result register can move.
`default_nettype none

module fifo_thread_scheduler_unit #(
  parameter int unsigned SLOTS = fts_pkg::SLOTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [fts_pkg::SLOT_W-1:0] cfg_wdata_i,
  fts_req_if.sink                         req_i,
  fts_res_if.source                       res_o
);

  localparam int unsigned PTR_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);

  // Configuration
  logic [fts_pkg::SLOT_W-1:0] idle_q;

  // Input register
  logic                        in_vld_q;
  logic [fts_pkg::REQ_W-1:0]   req_q;
  logic [fts_pkg::SLOT_W-1:0]  slot_q;

  // Scheduler state
  fts_pkg::slot_st_e           st_q [SLOTS];
  fts_pkg::slot_st_e           st_d [SLOTS];
  logic [PTR_W-1:0]            head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [fts_pkg::SLOT_W-1:0]  cur_q, cur_d;

  // Queue RAM access
  logic                        byp_q;
  logic [fts_pkg::SLOT_W-1:0]  byp_data_q;
  logic [fts_pkg::SLOT_W-1:0]  ram_rdata;
  logic [fts_pkg::SLOT_W-1:0]  head_slot;
  logic                        push, pop, push_ok;
  logic [fts_pkg::SLOT_W-1:0]  push_val;

  // Result register
  logic                        out_vld_q;
  logic [fts_pkg::SLOT_W-1:0]  run_q, prev_q;
  logic                        sw_q;
  fts_pkg::status_e            status_q, status_d;
  logic [fts_pkg::FREED_W-1:0] freed_q, freed_d;

  // Event evaluation helpers
  logic                        fire;
  logic                        cur_ok, sl_ok, idle_ok;
  logic [PTR_W-1:0]            cur_idx, sl_idx, nxt_idx;
  logic [fts_pkg::SLOT_W-1:0]  nxt_slot;
  logic                        run_nxt;
  logic [SLOTS-1:0]            reap_mask;
  logic [CNT_W-1:0]            nfree;

  // Handshake
  assign fire      = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || fire;

  // Range checks and indexes
  assign cur_ok  = 32'(cur_q) < SLOTS;
  assign sl_ok   = 32'(slot_q) < SLOTS;
  assign idle_ok = 32'(idle_q) < SLOTS;
  assign cur_idx = PTR_W'(cur_q);
  assign sl_idx  = PTR_W'(slot_q);
  assign nxt_idx = PTR_W'(nxt_slot);

  // Queue head with bypass of a write to the address being read
  assign head_slot = byp_q ? byp_data_q : ram_rdata;

  // Slots freed by a reap event
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      reap_mask[i] = (32'(cur_q) != i) && (st_q[i] == fts_pkg::ST_TERMINATED);
    end
  end
  assign nfree = CNT_W'($countones(reap_mask));

  // Event evaluation: next state and result
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      st_d[i] = st_q[i];
    end
    push     = 1'b0;
    push_val = slot_q;
    pop      = 1'b0;
    nxt_slot = head_slot;
    run_nxt  = 1'b0;
    status_d = fts_pkg::STS_DONE;
    freed_d  = '0;

    case (req_q)
      fts_pkg::REQ_ADMIT: begin
        if (sl_ok && st_q[sl_idx] == fts_pkg::ST_FREE) begin
          st_d[sl_idx] = fts_pkg::ST_READY;
          push = 1'b1;
        end else begin
          status_d = fts_pkg::STS_REJECTED;
        end
      end
      fts_pkg::REQ_YIELD: begin
        if (cur_q == idle_q || cnt_q == '0) begin
          status_d = fts_pkg::STS_IGNORED;
        end else begin
          pop     = 1'b1;
          run_nxt = 1'b1;
          if (cur_ok && st_q[cur_idx] != fts_pkg::ST_TERMINATED) begin
            st_d[cur_idx] = fts_pkg::ST_READY;
            push     = 1'b1;
            push_val = cur_q;
          end
        end
      end
      fts_pkg::REQ_BLOCK: begin
        if (cur_q == idle_q || (cnt_q == '0 && !idle_ok)) begin
          status_d = fts_pkg::STS_IGNORED;
        end else begin
          if (cur_ok) begin
            st_d[cur_idx] = fts_pkg::ST_BLOCKED;
          end
          run_nxt = 1'b1;
          if (cnt_q != '0) begin
            pop = 1'b1;
          end else begin
            nxt_slot = idle_q;
          end
        end
      end
      fts_pkg::REQ_UNBLOCK: begin
        if (sl_ok && st_q[sl_idx] == fts_pkg::ST_BLOCKED) begin
          st_d[sl_idx] = fts_pkg::ST_READY;
          push = 1'b1;
        end else begin
          status_d = fts_pkg::STS_REJECTED;
        end
      end
      fts_pkg::REQ_TERMINATE: begin
        if (cur_ok) begin
          st_d[cur_idx] = fts_pkg::ST_TERMINATED;
        end
      end
      fts_pkg::REQ_REAP: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (reap_mask[i]) begin
            st_d[i] = fts_pkg::ST_FREE;
          end
        end
        if (32'(nfree) > fts_pkg::FREED_MAX) begin
          freed_d = fts_pkg::FREED_W'(fts_pkg::FREED_MAX);
        end else begin
          freed_d = fts_pkg::FREED_W'(nfree);
        end
      end
      default: begin
        status_d = fts_pkg::STS_IGNORED;
      end
    endcase

    // Dispatch the chosen slot
    cur_d = cur_q;
    if (run_nxt) begin
      if (32'(nxt_slot) < SLOTS) begin
        st_d[nxt_idx] = fts_pkg::ST_RUNNING;
      end
      cur_d = nxt_slot;
    end
  end

  // Queue pointers; a push after a pop always has room
  assign push_ok = fire && push && (pop || cnt_q != CNT_FULL);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (fire && pop) begin
      head_d = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
    end
    if (push_ok) begin
      tail_d = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
    end
    if (fire && pop && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end else if (push_ok && !(fire && pop)) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Ready queue storage
  fts_ram #(
    .WIDTH (fts_pkg::SLOT_W),
    .DEPTH (SLOTS)
  ) u_ready_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (tail_q),
    .wdata_i (push_val),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  // Bypass data register
  always_ff @(posedge clk_i) begin
    byp_data_q <= push_val;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q    <= fts_pkg::IDLE_RST;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      cur_q     <= '0;
      byp_q     <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        st_q[i] <= (i == 0) ? fts_pkg::ST_RUNNING : fts_pkg::ST_FREE;
      end
    end else begin
      if (cfg_we_i) begin
        idle_q <= cfg_wdata_i;
      end
      if (req_i.ready) begin
        in_vld_q <= req_i.valid;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      byp_q  <= push_ok && (tail_q == head_d);
      if (fire) begin
        cur_q <= cur_d;
        for (int i = 0; i < SLOTS; i++) begin
          st_q[i] <= st_d[i];
        end
      end
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (req_i.ready) begin
      req_q  <= req_i.req_type;
      slot_q <= req_i.thread_slot;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      run_q    <= cur_d;
      prev_q   <= cur_q;
      sw_q     <= cur_d != cur_q;
      status_q <= status_d;
      freed_q  <= freed_d;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.running_slot  = run_q;
  assign res_o.switched      = sw_q;
  assign res_o.previous_slot = prev_q;
  assign res_o.status        = status_q;
  assign res_o.freed_count   = freed_q;

  // Queue never holds more than SLOTS entries
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= SLOTS)
    else $error("ready queue count above depth");

  // Tail stays head plus count, modulo the depth
  a_ptr_cons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(head_q) + 32'(cnt_q) == 32'(tail_q)) ||
    (32'(head_q) + 32'(cnt_q) == 32'(tail_q) + SLOTS))
    else $error("ready queue pointers inconsistent");

  // An ignored event never switches the running slot
  a_ign_no_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_q == fts_pkg::STS_IGNORED) |-> !sw_q)
    else $error("ignored event switched slots");

  // A request code past the last defined one yields an ignored result
  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && req_q > fts_pkg::REQ_REAP) |=>
    (out_vld_q && status_q == fts_pkg::STS_IGNORED))
    else $error("unknown request not ignored");

endmodule

`default_nettype wire

// ----- design/fts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fts_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- verif/tb_fifo_thread_scheduler_unit.sv -----
// Testbench for the FIFO thread scheduler: directed and random scheduling requests.
module tb_fifo_thread_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = fts_pkg::SLOTS_DEF;
  localparam int          CLK_PERIOD  = 8;
  localparam int          RST_CYCLES  = 12;
  localparam int          MAX_WAIT    = 9;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          RANDOM_GOAL = 1400;
  localparam int          MAX_REPORTS = 10;

  // Request codes the block does not define
  localparam logic [fts_pkg::REQ_W-1:0] REQ_BAD_A = 3'd6;
  localparam logic [fts_pkg::REQ_W-1:0] REQ_BAD_B = 3'd7;

  typedef struct packed {
    logic [fts_pkg::SLOT_W-1:0]   running;
    logic                         switched;
    logic [fts_pkg::SLOT_W-1:0]   previous;
    logic [fts_pkg::STATUS_W-1:0] status;
    logic [fts_pkg::FREED_W-1:0]  freed;
  } sched_res_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [fts_pkg::SLOT_W-1:0] cfg_wdata_i;

  fts_req_if req_if ();
  fts_res_if res_if ();

  fifo_thread_scheduler_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Scheduler state as the testbench sees it
  fts_pkg::slot_st_e          slot_st [SLOTS];
  logic [fts_pkg::SLOT_W-1:0] ready_q [$];
  logic [fts_pkg::SLOT_W-1:0] run_slot;
  logic [fts_pkg::SLOT_W-1:0] idle_slot_cfg;

  sched_res_t sched_results_due [$];

  // Run statistics
  int  errors;
  int  req_taken;
  int  res_taken;
  int  effective_cnt;
  int  switch_cnt;
  int  idle_writes;
  int  kind_cnt [8];
  int  quiet_cycles;
  bit  steady;

  sched_res_t pred_r;
  sched_res_t want_r;
  sched_res_t got_r;
  bit         bad;

  // Append to the ready queue; a full queue drops the slot
  function automatic void queue_ready(logic [fts_pkg::SLOT_W-1:0] slot);
    if (ready_q.size() < SLOTS) ready_q.push_back(slot);
  endfunction

  // Apply one scheduling event to the state and return its result
  function automatic sched_res_t schedule_event(logic [fts_pkg::REQ_W-1:0] kind,
                                                logic [fts_pkg::SLOT_W-1:0] slot);
    sched_res_t                 r;
    logic [fts_pkg::SLOT_W-1:0] nxt;
    r = '0;
    r.previous = run_slot;
    case (kind)
      fts_pkg::REQ_ADMIT: begin
        if (slot_st[slot] == fts_pkg::ST_FREE) begin
          slot_st[slot] = fts_pkg::ST_READY;
          queue_ready(slot);
        end else begin
          r.status = fts_pkg::STS_REJECTED;
        end
      end
      fts_pkg::REQ_YIELD: begin
        if (run_slot == idle_slot_cfg || ready_q.size() == 0) begin
          r.status = fts_pkg::STS_IGNORED;
        end else begin
          nxt = ready_q.pop_front();
          // a terminated slot drops out instead of going back in line
          if (slot_st[run_slot] != fts_pkg::ST_TERMINATED) begin
            slot_st[run_slot] = fts_pkg::ST_READY;
            queue_ready(run_slot);
          end
          run_slot = nxt;
          slot_st[nxt] = fts_pkg::ST_RUNNING;
        end
      end
      fts_pkg::REQ_BLOCK: begin
        if (run_slot == idle_slot_cfg) begin
          r.status = fts_pkg::STS_IGNORED;
        end else begin
          slot_st[run_slot] = fts_pkg::ST_BLOCKED;
          nxt = (ready_q.size() != 0) ? ready_q.pop_front() : idle_slot_cfg;
          run_slot = nxt;
          slot_st[nxt] = fts_pkg::ST_RUNNING;
        end
      end
      fts_pkg::REQ_UNBLOCK: begin
        if (slot_st[slot] == fts_pkg::ST_BLOCKED) begin
          slot_st[slot] = fts_pkg::ST_READY;
          queue_ready(slot);
        end else begin
          r.status = fts_pkg::STS_REJECTED;
        end
      end
      fts_pkg::REQ_TERMINATE: slot_st[run_slot] = fts_pkg::ST_TERMINATED;
      fts_pkg::REQ_REAP: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (s != run_slot && slot_st[s] == fts_pkg::ST_TERMINATED) begin
            slot_st[s] = fts_pkg::ST_FREE;
            if (r.freed != fts_pkg::FREED_W'(fts_pkg::FREED_MAX)) r.freed++;
          end
        end
      end
      default: r.status = fts_pkg::STS_IGNORED;
    endcase
    r.running  = run_slot;
    r.switched = (run_slot != r.previous);
    return r;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Random slot currently in the given state, else the fallback
  function automatic logic [fts_pkg::SLOT_W-1:0] pick_slot_in(
      fts_pkg::slot_st_e st, logic [fts_pkg::SLOT_W-1:0] fallback);
    logic [fts_pkg::SLOT_W-1:0] cand [$];
    for (int s = 0; s < SLOTS; s++)
      if (slot_st[s] == st) cand.push_back(fts_pkg::SLOT_W'(s));
    if (cand.size() == 0) return fallback;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // Mostly well-formed requests: admit free slots, unblock blocked ones
  function automatic void pick_random_request(output logic [fts_pkg::REQ_W-1:0] kind,
                                              output logic [fts_pkg::SLOT_W-1:0] slot);
    int roll;
    roll = $urandom_range(0, 99);
    slot = fts_pkg::SLOT_W'($urandom);
    if (roll < 22) begin
      kind = fts_pkg::REQ_ADMIT;
      if ($urandom_range(0, 3) != 0) slot = pick_slot_in(fts_pkg::ST_FREE, slot);
    end else if (roll < 47) begin
      kind = fts_pkg::REQ_YIELD;
    end else if (roll < 62) begin
      kind = fts_pkg::REQ_BLOCK;
    end else if (roll < 78) begin
      kind = fts_pkg::REQ_UNBLOCK;
      if ($urandom_range(0, 3) != 0) slot = pick_slot_in(fts_pkg::ST_BLOCKED, slot);
    end else if (roll < 86) begin
      kind = fts_pkg::REQ_TERMINATE;
    end else if (roll < 95) begin
      kind = fts_pkg::REQ_REAP;
    end else begin
      kind = $urandom_range(0, 1) ? REQ_BAD_A : REQ_BAD_B;
    end
  endfunction

  // Send one request; starts and returns at a falling edge
  task automatic send_req(input logic [fts_pkg::REQ_W-1:0] kind,
                          input logic [fts_pkg::SLOT_W-1:0] slot);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_if.valid       = 1'b0;
      req_if.req_type    = fts_pkg::REQ_W'($urandom);
      req_if.thread_slot = fts_pkg::SLOT_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       = 1'b1;
    req_if.req_type    = kind;
    req_if.thread_slot = slot;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every result is back
  task automatic drain_results();
    req_if.valid = 1'b0;
    while (sched_results_due.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_idle_slot(input logic [fts_pkg::SLOT_W-1:0] value);
    drain_results();
    cfg_we_i      = 1'b1;
    cfg_wdata_i   = value;
    idle_slot_cfg = value;
    idle_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Empty-queue yield and undefined request codes
  task automatic test_ignored_requests();
    send_req(fts_pkg::REQ_YIELD, 4'd0);
    send_req(REQ_BAD_A, 4'd15);
    send_req(REQ_BAD_B, 4'd0);
  endtask

  // Admit of busy and free slots, then a yield that switches
  task automatic test_admit_yield();
    send_req(fts_pkg::REQ_ADMIT, 4'd0);
    send_req(fts_pkg::REQ_ADMIT, 4'd15);
    send_req(fts_pkg::REQ_ADMIT, 4'd15);
    send_req(fts_pkg::REQ_ADMIT, 4'd2);
    send_req(fts_pkg::REQ_YIELD, 4'd9);
  endtask

  // Terminated slot yields without requeue; reap skips the running slot
  task automatic test_terminate_reap();
    send_req(fts_pkg::REQ_TERMINATE, 4'd0);
    send_req(fts_pkg::REQ_YIELD, 4'd0);
    send_req(fts_pkg::REQ_REAP, 4'd0);
    send_req(fts_pkg::REQ_TERMINATE, 4'd0);
    send_req(fts_pkg::REQ_REAP, 4'd0);
  endtask

  // Block down to the idle slot, ignored events there, unblock
  task automatic test_block_unblock();
    send_req(fts_pkg::REQ_BLOCK, 4'd0);
    send_req(fts_pkg::REQ_BLOCK, 4'd0);
    send_req(fts_pkg::REQ_BLOCK, 4'd0);
    send_req(fts_pkg::REQ_YIELD, 4'd0);
    send_req(fts_pkg::REQ_UNBLOCK, 4'd2);
    send_req(fts_pkg::REQ_UNBLOCK, 4'd5);
    send_req(fts_pkg::REQ_UNBLOCK, 4'd0);
  endtask

  // Idle slot at both ends of its range
  task automatic test_idle_extremes();
    set_idle_slot(4'd15);
    send_req(fts_pkg::REQ_YIELD, 4'd0);
    send_req(fts_pkg::REQ_BLOCK, 4'd0);
    send_req(fts_pkg::REQ_BLOCK, 4'd0);
    send_req(fts_pkg::REQ_BLOCK, 4'd0);
    send_req(fts_pkg::REQ_BLOCK, 4'd0);
    set_idle_slot(4'd0);
    send_req(fts_pkg::REQ_BLOCK, 4'd0);
  endtask

  // Phases of random traffic, each under a fresh idle slot
  task automatic test_random_traffic();
    int                         goal;
    int                         phase;
    int                         phase_len;
    int                         stuck;
    logic [fts_pkg::SLOT_W-1:0] nxt_idle;
    logic [fts_pkg::REQ_W-1:0]  kind;
    logic [fts_pkg::SLOT_W-1:0] slot;
    goal  = req_taken + RANDOM_GOAL;
    phase = 0;
    while (req_taken < goal) begin
      case (phase % 5)
        0:       nxt_idle = 4'd0;
        1:       nxt_idle = 4'd15;
        default: nxt_idle = fts_pkg::SLOT_W'($urandom);
      endcase
      // idling the running slot freezes switching, so keep it rare
      if (nxt_idle == run_slot && $urandom_range(0, 3) != 0) nxt_idle = nxt_idle + 1'b1;
      set_idle_slot(nxt_idle);
      steady    = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 160);
      stuck     = 0;
      repeat (phase_len) begin
        if (run_slot == idle_slot_cfg) stuck++;
        if (stuck > 10 || req_taken >= goal) break;
        pick_random_request(kind, slot);
        send_req(kind, slot);
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // Result side: random stalls before each result
  initial begin
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = draw_wait();
      if (stall > 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        pred_r = schedule_event(req_if.req_type, req_if.thread_slot);
        sched_results_due.push_back(pred_r);
        req_taken++;
        kind_cnt[req_if.req_type]++;
        if (pred_r.status != fts_pkg::STS_IGNORED) effective_cnt++;
        if (pred_r.switched) switch_cnt++;
      end
      if (res_if.valid && res_if.ready) begin
        res_taken++;
        got_r = '{running: res_if.running_slot, switched: res_if.switched,
                  previous: res_if.previous_slot, status: res_if.status,
                  freed: res_if.freed_count};
        if (sched_results_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result with no request pending: run %0d prev %0d st %0d",
                     $realtime, got_r.running, got_r.previous, got_r.status);
        end else begin
          want_r = sched_results_due.pop_front();
          bad = (got_r.running !== want_r.running) || (got_r.switched !== want_r.switched) ||
                (got_r.previous !== want_r.previous) || (got_r.status !== want_r.status) ||
                (got_r.freed !== want_r.freed);
          if (bad) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"%0t: result %0d mismatch (exp/got): run %0d/%0d sw %0b/%0b ",
                        "prev %0d/%0d status %0d/%0d freed %0d/%0d"},
                       $realtime, res_taken, want_r.running, got_r.running,
                       want_r.switched, got_r.switched, want_r.previous, got_r.previous,
                       want_r.status, got_r.status, want_r.freed, got_r.freed);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no traffic for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, sched_results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.req_type    = '0;
    req_if.thread_slot = '0;
    steady             = 1'b0;
    // state after reset: slot 0 running, all else free
    foreach (slot_st[s]) slot_st[s] = fts_pkg::ST_FREE;
    slot_st[0]    = fts_pkg::ST_RUNNING;
    run_slot      = '0;
    idle_slot_cfg = fts_pkg::IDLE_RST;
    ready_q.delete();

    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_ignored_requests();
    test_admit_yield();
    test_terminate_reap();
    test_block_unblock();
    test_idle_extremes();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d requests: admit %0d, yield %0d, block %0d, unblock %0d, %s",
             req_taken, kind_cnt[fts_pkg::REQ_ADMIT], kind_cnt[fts_pkg::REQ_YIELD],
             kind_cnt[fts_pkg::REQ_BLOCK], kind_cnt[fts_pkg::REQ_UNBLOCK],
             $sformatf("terminate %0d, reap %0d, undefined %0d",
                       kind_cnt[fts_pkg::REQ_TERMINATE], kind_cnt[fts_pkg::REQ_REAP],
                       kind_cnt[REQ_BAD_A] + kind_cnt[REQ_BAD_B]));
    $display("Checked %0d results (%0d with effect) with %0d slot switches over %0d %s",
             res_taken, effective_cnt, switch_cnt, idle_writes,
             $sformatf("idle-slot settings, %0d bad", errors));
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
